@@ hw/rtl/tcfl_pkg.sv @@
// Package for the two-client first-come lock: payload structs, owner and
// request-kind codes, stamp width and the rest-timer constants.
// Depends on nothing; every other file of the block imports it.
package tcfl_pkg;

   // Width of the arrival stamps that are stored and compared.
   localparam int SEQ_BITS = 32;

   // Rest timer is Q4.16 seconds.
   localparam int REST_BITS = 20;
   localparam int DT_BITS   = 16;

   localparam logic [31:0] RNG_SEED     = 32'h4152_4254;
   localparam logic [31:0] RNG_ZERO_FIX = 32'h9E37_79B9;

   // Largest tick that is honored: 0.25 s in Q0.16.
   localparam logic [DT_BITS-1:0]   DT_MAX    = DT_BITS'(16384);
   // Base rest length: 10 s in Q4.16.
   localparam logic [REST_BITS-1:0] REST_BASE = REST_BITS'(10 << 16);

   typedef logic [SEQ_BITS-1:0] stamp_type;

   localparam stamp_type STAMP_NONE = '1;

   typedef enum logic [1:0] {
      OWN_NONE = 2'd0,
      OWN_A    = 2'd1,
      OWN_B    = 2'd2
   } owner_type;

   typedef enum logic [1:0] {
      KIND_COMMIT = 2'd0,
      KIND_TICK   = 2'd1,
      KIND_RESET  = 2'd2
   } kind_type;

   typedef struct packed {
      logic [1:0]         req_type;
      logic               a_request;
      logic               a_hold;
      logic               a_cancel;
      logic               a_release;
      logic               b_request;
      logic               b_hold;
      logic               b_cancel;
      logic               b_release;
      logic [31:0]        arrival_seq;
      logic [DT_BITS-1:0] tick_dt;
   } req_payload_type;

   typedef struct packed {
      logic [1:0] owner;
      logic       grace_active;
      logic       a_waiting;
      logic       b_waiting;
   } rsp_payload_type;

   // One step of the xorshift32 generator, with the zero guards on both sides.
   function automatic logic [31:0] rng_step(input logic [31:0] cur);
      logic [31:0] v;
      v = (cur == 32'd0) ? RNG_SEED : cur;
      v = v ^ (v << 13);
      v = v ^ (v >> 17);
      v = v ^ (v << 5);
      return (v == 32'd0) ? RNG_ZERO_FIX : v;
   endfunction

endpackage

@@ hw/rtl/tcfl_in_reg.sv @@
// Input register stage of the two-client lock: holds one accepted request.
// Depends on tcfl_pkg for the request payload struct.
module tcfl_in_reg
   import tcfl_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  req_payload_type req_data,
   output logic            stage_valid,
   output req_payload_type stage_data,
   input  logic            stage_take
);

   logic            valid_ff;
   logic            valid_in;
   req_payload_type data_ff;

   // A slot is free when empty or when its request leaves in this cycle.
   assign req_ready = !valid_ff || stage_take;

   always_comb begin
      if (req_valid && req_ready) begin
         valid_in = 1'b1;
      end else if (stage_take) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         data_ff <= req_data;
      end
   end

   assign stage_valid = valid_ff;
   assign stage_data  = data_ff;

endmodule

@@ hw/rtl/tcfl_lock_core.sv @@
// Lock state and its combinational update: owner, pending stamps, rest timer
// and random generator. Depends on tcfl_pkg for codes, structs and rng_step.
module tcfl_lock_core
   import tcfl_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            step_en,
   input  req_payload_type step_data,
   output rsp_payload_type step_rsp
);

   owner_type             holder_ff, holder_in;
   stamp_type             a_arrival_ff, a_arrival_in;
   stamp_type             b_arrival_ff, b_arrival_in;
   logic [REST_BITS-1:0]  rest_time_ff, rest_time_in;
   logic [31:0]           rng_word_ff, rng_word_in;

   logic [31:0]           rng_next;
   logic [REST_BITS-1:0]  rest_new;
   logic [DT_BITS-1:0]    dt_clamped;
   stamp_type             stamp;
   owner_type             h;
   stamp_type             pa, pb;
   logic [REST_BITS-1:0]  rt;
   logic [31:0]           rw;

   assign rng_next   = rng_step(rng_word_ff);
   assign rest_new   = REST_BASE + {2'b00, rng_next[15:0], 2'b00};
   assign dt_clamped = (step_data.tick_dt > DT_MAX) ? DT_MAX : step_data.tick_dt;
   assign stamp      = SEQ_BITS'(step_data.arrival_seq);

   always_comb begin
      h  = holder_ff;
      pa = a_arrival_ff;
      pb = b_arrival_ff;
      rt = rest_time_ff;
      rw = rng_word_ff;
      case (step_data.req_type)
         KIND_COMMIT: begin
            // Flags of A, then of B; at most one of them frees the lock.
            if (step_data.a_cancel || step_data.a_release) begin
               pa = STAMP_NONE;
            end
            if (h == OWN_A && (step_data.a_release || !step_data.a_hold)) begin
               pa = STAMP_NONE;
               h  = OWN_NONE;
               rt = rest_new;
               rw = rng_next;
            end
            if (step_data.b_cancel || step_data.b_release) begin
               pb = STAMP_NONE;
            end
            if (h == OWN_B && (step_data.b_release || !step_data.b_hold)) begin
               pb = STAMP_NONE;
               h  = OWN_NONE;
               rt = rest_new;
               rw = rng_next;
            end
            // New requests keep the oldest stamp; the owner's own is ignored.
            if (step_data.a_request && !step_data.a_cancel && !step_data.a_release
                && h != OWN_A && stamp < pa) begin
               pa = stamp;
            end
            if (step_data.b_request && !step_data.b_cancel && !step_data.b_release
                && h != OWN_B && stamp < pb) begin
               pb = stamp;
            end
            // Grant to the oldest request, A on a tie, unless resting.
            if (h == OWN_NONE && rt == '0 && !(pa == STAMP_NONE && pb == STAMP_NONE)) begin
               if (pa <= pb) begin
                  h  = OWN_A;
                  pa = STAMP_NONE;
               end else begin
                  h  = OWN_B;
                  pb = STAMP_NONE;
               end
            end
         end
         KIND_TICK: begin
            rt = (rt > REST_BITS'(dt_clamped)) ? rt - REST_BITS'(dt_clamped) : '0;
         end
         KIND_RESET: begin
            h  = OWN_NONE;
            pa = STAMP_NONE;
            pb = STAMP_NONE;
            rt = '0;
            rw = (rng_word_ff == 32'd0) ? RNG_SEED : rng_word_ff;
         end
         default: begin
         end
      endcase

      holder_in    = h;
      a_arrival_in = pa;
      b_arrival_in = pb;
      rest_time_in = rt;
      rng_word_in  = rw;

      step_rsp.owner        = h;
      step_rsp.grace_active = (rt != '0);
      step_rsp.a_waiting    = (pa != STAMP_NONE);
      step_rsp.b_waiting    = (pb != STAMP_NONE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         holder_ff    <= OWN_NONE;
         a_arrival_ff <= STAMP_NONE;
         b_arrival_ff <= STAMP_NONE;
         rest_time_ff <= '0;
         rng_word_ff  <= RNG_SEED;
      end else if (step_en) begin
         holder_ff    <= holder_in;
         a_arrival_ff <= a_arrival_in;
         b_arrival_ff <= b_arrival_in;
         rest_time_ff <= rest_time_in;
         rng_word_ff  <= rng_word_in;
      end
   end

endmodule

@@ hw/rtl/tcfl_out_reg.sv @@
// Result register of the two-client lock: holds one result until taken.
// Depends on tcfl_pkg for the result payload struct.
module tcfl_out_reg
   import tcfl_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            load,
   input  rsp_payload_type load_data,
   output logic            can_load,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output rsp_payload_type rsp_data
);

   logic            valid_ff;
   logic            valid_in;
   rsp_payload_type data_ff;

   assign can_load = !valid_ff || rsp_ready;

   always_comb begin
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= load_data;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule

@@ hw/rtl/two_client_fcfs_lock_with_random_rest.sv @@
// Two-client first-come lock with a random rest period after each release.
// Path: the input register holds an accepted request, then the lock update is
// written into the result register together with the state. Throughput: one
// request per cycle unless results stall; the state update is the loop.
// Reset (synchronous, active high) empties both stages, clears the owner,
// pending requests and rest timer, and loads the generator seed.
module two_client_fcfs_lock_with_random_rest
   import tcfl_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  req_payload_type req_data,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output rsp_payload_type rsp_data
);

   logic            stage_valid;
   req_payload_type stage_data;
   logic            stage_take;
   logic            out_can_load;
   rsp_payload_type step_rsp;

   // The registered request is applied to the lock state in the same cycle
   // that its result moves into the result register, so state and results
   // always advance together and a stalled result never loses an update.
   assign stage_take = stage_valid && out_can_load;

   tcfl_in_reg u_in_reg (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .stage_valid (stage_valid),
      .stage_data  (stage_data),
      .stage_take  (stage_take)
   );

   // Commit, tick and reset requests all resolve in one pass of short logic:
   // two flag checks, two stamp minimums, one grant compare, one xorshift and
   // one clamped subtract.
   tcfl_lock_core u_lock_core (
      .clock     (clock),
      .reset     (reset),
      .step_en   (stage_take),
      .step_data (stage_data),
      .step_rsp  (step_rsp)
   );

   // The result register loads a new result in the same cycle that the old one is taken.
   tcfl_out_reg u_out_reg (
      .clock     (clock),
      .reset     (reset),
      .load      (stage_take),
      .load_data (step_rsp),
      .can_load  (out_can_load),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

@@ dv/tb.sv @@
`timescale 1ns / 1ps
// Testbench for the two-client first-come lock with random rest periods.
// Holds its own model of the lock, predicts every result and checks them in order.
// Depends on tcfl_pkg and on two_client_fcfs_lock_with_random_rest only.
module tb;
   import tcfl_pkg::*;

   // The watchdog limit is far above the slowest legal run. That run is about
   // 2100 requests, each waiting out a long receiver stall and sender gap.
   localparam int CYCLE_LIMIT  = 400000;
   // The block answers through its input and result registers. The drain wait
   // after the last expected result catches stray results at the end.
   localparam int DRAIN_CYCLES = 10;
   localparam int REPORT_LINES = 30;

   // Request kind 3 has no name in the package. The block must only report its state.
   localparam logic [1:0] KIND_UNUSED = 2'd3;

   // Per-client intent bits, in the order {request, hold, cancel, release}.
   localparam logic [3:0] F_REQ     = 4'b1000;
   localparam logic [3:0] F_HOLD    = 4'b0100;
   localparam logic [3:0] F_CANCEL  = 4'b0010;
   localparam logic [3:0] F_RELEASE = 4'b0001;

   logic            clock;
   logic            reset;
   logic            req_valid;
   logic            req_ready;
   req_payload_type req_data;
   logic            rsp_valid;
   logic            rsp_ready;
   rsp_payload_type rsp_data;

   // Idle rates in percent for the sender and the receiver.
   int req_idle_pct;
   int rsp_idle_pct;

   int error_count;
   int cycle_count;
   int results_checked;
   int commit_count;
   int tick_count;
   int reset_item_count;
   int grants_a;
   int grants_b;
   int rest_starts;

   // Our own copy of the lock state, updated once for each accepted request.
   owner_type            lock_owner;
   stamp_type            pend_stamp [1:2];
   logic [REST_BITS-1:0] rest_left;
   logic [31:0]          rest_rng;

   // Results still owed by the block, oldest first.
   rsp_payload_type expected_states [$];

   two_client_fcfs_lock_with_random_rest i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   initial clock = 1'b0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles with %0d results outstanding.",
                  cycle_count, expected_states.size());
         $display("DONE: errors detected");
         $finish;
      end
   end

   // The receiver changes ready at the falling edge, as all testbench inputs do.
   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99) >= rsp_idle_pct);
   end

   function automatic bit chance(input int pct);
      return $urandom_range(99) < pct;
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      error_count++;
      if (error_count <= REPORT_LINES) begin
         $display("%0t: mismatch in %s: got %0d, expected %0d", $time, what, got, want);
      end
   endtask

   // The rest of this block is the prediction model.

   // The flags act first. Cancel or release drops the pending request. The
   // owner frees the lock if it releases or stops holding. Each time the lock
   // is freed, a rest period starts, drawn from the xorshift32 generator.
   function automatic void apply_client_flags(input owner_type who, input logic hold,
                                              input logic cancel, input logic drop);
      logic [31:0] x;
      if (cancel || drop) begin
         pend_stamp[who] = STAMP_NONE;
      end
      if (lock_owner == who && (drop || !hold)) begin
         pend_stamp[who] = STAMP_NONE;
         lock_owner      = OWN_NONE;
         x = (rest_rng == '0) ? RNG_SEED : rest_rng;
         x ^= x << 13;
         x ^= x >> 17;
         x ^= x << 5;
         rest_rng  = (x == '0) ? RNG_ZERO_FIX : x;
         rest_left = REST_BASE + REST_BITS'({rest_rng[15:0], 2'b00});
         rest_starts++;
      end
   endfunction

   // A client's pending stamp keeps the minimum of what it has asked with.
   // A request from the owner is ignored. So is one that comes with cancel or release.
   function automatic void post_client_request(input owner_type who, input logic want_lock,
                                               input logic cancel, input logic drop,
                                               input stamp_type stamp);
      if (want_lock && !cancel && !drop && lock_owner != who && stamp < pend_stamp[who]) begin
         pend_stamp[who] = stamp;
      end
   endfunction

   function automatic rsp_payload_type step_lock(input req_payload_type r);
      rsp_payload_type    s;
      stamp_type          stamp;
      logic [DT_BITS-1:0] dt;
      stamp = stamp_type'(r.arrival_seq);
      case (r.req_type)
         KIND_COMMIT: begin
            apply_client_flags(OWN_A, r.a_hold, r.a_cancel, r.a_release);
            apply_client_flags(OWN_B, r.b_hold, r.b_cancel, r.b_release);
            post_client_request(OWN_A, r.a_request, r.a_cancel, r.a_release, stamp);
            post_client_request(OWN_B, r.b_request, r.b_cancel, r.b_release, stamp);
            // Grant to the older stamp, and to A on a tie, but never during a rest.
            if (lock_owner == OWN_NONE && rest_left == '0 &&
                (pend_stamp[OWN_A] != STAMP_NONE || pend_stamp[OWN_B] != STAMP_NONE)) begin
               if (pend_stamp[OWN_A] <= pend_stamp[OWN_B]) begin
                  lock_owner = OWN_A;
                  grants_a++;
               end else begin
                  lock_owner = OWN_B;
                  grants_b++;
               end
               pend_stamp[lock_owner] = STAMP_NONE;
            end
         end
         KIND_TICK: begin
            dt = (r.tick_dt > DT_MAX) ? DT_MAX : r.tick_dt;
            rest_left = (rest_left > REST_BITS'(dt)) ? rest_left - REST_BITS'(dt) : '0;
         end
         KIND_RESET: begin
            lock_owner        = OWN_NONE;
            pend_stamp[OWN_A] = STAMP_NONE;
            pend_stamp[OWN_B] = STAMP_NONE;
            rest_left         = '0;
            if (rest_rng == '0) begin
               rest_rng = RNG_SEED;
            end
         end
         default: begin
         end
      endcase
      s.owner        = lock_owner;
      s.grace_active = (rest_left != '0);
      s.a_waiting    = (pend_stamp[OWN_A] != STAMP_NONE);
      s.b_waiting    = (pend_stamp[OWN_B] != STAMP_NONE);
      return s;
   endfunction

   // At each rising edge the result is checked first, and only then is the
   // new request predicted. A request and a result in the same cycle can
   // then never be matched with each other.
   always @(posedge clock) begin
      rsp_payload_type want;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            results_checked++;
            if (expected_states.size() == 0) begin
               report_mismatch("result with no request outstanding", rsp_data, 0);
            end else begin
               want = expected_states.pop_front();
               if (rsp_data.owner !== want.owner)
                  report_mismatch("owner", rsp_data.owner, want.owner);
               if (rsp_data.grace_active !== want.grace_active)
                  report_mismatch("grace_active", rsp_data.grace_active, want.grace_active);
               if (rsp_data.a_waiting !== want.a_waiting)
                  report_mismatch("a_waiting", rsp_data.a_waiting, want.a_waiting);
               if (rsp_data.b_waiting !== want.b_waiting)
                  report_mismatch("b_waiting", rsp_data.b_waiting, want.b_waiting);
            end
         end
         if (req_valid && req_ready) begin
            expected_states.push_back(step_lock(req_data));
         end
      end
   end

   // Builds a request of the given kind. The fields that this kind ignores get random values.
   function automatic req_payload_type kind_item(input logic [1:0] kind);
      req_payload_type r;
      logic [63:0]     bits;
      bits       = {$urandom, $urandom};
      r          = bits[$bits(req_payload_type)-1:0];
      r.req_type = kind;
      return r;
   endfunction

   function automatic req_payload_type commit_item(input logic [3:0] a_intent,
                                                   input logic [3:0] b_intent,
                                                   input logic [31:0] stamp);
      req_payload_type r;
      r = kind_item(KIND_COMMIT);
      {r.a_request, r.a_hold, r.a_cancel, r.a_release} = a_intent;
      {r.b_request, r.b_hold, r.b_cancel, r.b_release} = b_intent;
      r.arrival_seq = stamp;
      return r;
   endfunction

   function automatic req_payload_type tick_item(input logic [DT_BITS-1:0] dt);
      req_payload_type r;
      r         = kind_item(KIND_TICK);
      r.tick_dt = dt;
      return r;
   endfunction

   function automatic logic [3:0] random_intent();
      return {chance(50), chance(85), chance(8), chance(8)};
   endfunction

   // Starts at a falling edge and returns at the falling edge after the
   // request is accepted. Valid stays high between requests sent back to back.
   task automatic send_request(input req_payload_type item);
      while ($urandom_range(99) < req_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid = 1'b1;
      req_data  = item;
      do @(posedge clock); while (req_ready !== 1'b1);
      @(negedge clock);
      case (item.req_type)
         KIND_COMMIT: commit_count++;
         KIND_TICK:   tick_count++;
         KIND_RESET:  reset_item_count++;
         default: begin
         end
      endcase
   endtask

   // A request of the unused kind, with every other bit set, must leave the state alone.
   task automatic test_unused_kind();
      req_payload_type r;
      r          = '1;
      r.req_type = KIND_UNUSED;
      send_request(r);
   endtask

   // Tie break, both stamp extremes, requests from the owner, cancel, and release of the lock.
   task automatic test_grant_order();
      send_request(commit_item(F_REQ, F_REQ, 32'h0));                // equal stamps: A wins
      send_request(commit_item(F_HOLD, F_REQ, 32'hFFFF_FFFF));       // all-ones keeps B at 0
      send_request(commit_item(F_HOLD | F_REQ, '0, 32'd7));          // owner's request ignored
      send_request(commit_item(F_HOLD, F_CANCEL, 32'd0));            // B withdraws
      send_request(commit_item(F_HOLD, F_REQ | F_CANCEL, 32'd2));    // cancel beats request
      send_request(commit_item(F_HOLD, F_REQ, 32'hFFFF_FFFE));       // largest real stamp
      send_request(commit_item(F_HOLD | F_RELEASE, '0, 32'd0));      // A frees, rest starts
      send_request(commit_item(F_REQ, F_HOLD, 32'd1));               // no grant while resting
   endtask

   // Ticks during a rest: a long tick is clamped, a zero tick does nothing,
   // and a tick never grants the lock.
   task automatic test_rest_ticks();
      send_request(tick_item(16'hFFFF));
      send_request(tick_item(16'h0000));
      send_request(tick_item(DT_MAX));
      send_request(tick_item(DT_MAX + 16'd1));
      send_request(tick_item(16'd1));
      send_request(commit_item('0, F_RELEASE, 32'd0));              // release by a non-owner
   endtask

   // A reset request clears the owner, the pending requests and the rest. The generator keeps going.
   task automatic test_reset_item();
      send_request(kind_item(KIND_RESET));
      send_request(commit_item(F_REQ, F_REQ, 32'hFFFF_FFFE));        // granted at once
      send_request(commit_item(F_HOLD | F_RELEASE, F_HOLD, 32'd0));  // release wins over hold
      send_request(commit_item(F_REQ, F_REQ, 32'd3));                // both wait in the rest
      send_request(kind_item(KIND_RESET));
      send_request(commit_item('0, F_REQ | F_HOLD, 32'd4));          // B granted
      send_request(commit_item('0, '0, 32'd0));                      // B stops holding
   endtask

   // Random traffic in episodes. A few commits carry random intents. Then a
   // burst of mostly long ticks wears down the rest, so that later commits can
   // grant again. Reset requests, unused kinds and fully random requests are mixed in.
   task automatic test_random_traffic(input int sender_idle, input int receiver_idle,
                                      input int target);
      int              sent;
      int              burst;
      logic [31:0]     stamp;
      req_payload_type item;
      req_idle_pct = sender_idle;
      rsp_idle_pct = receiver_idle;
      sent = 0;
      while (sent < target) begin
         burst = $urandom_range(1, 8);
         repeat (burst) begin
            // Small stamps give ties and reorderings. The top two stamps test the all-ones case.
            case ($urandom_range(9))
               0:       stamp = 32'hFFFF_FFFF;
               1:       stamp = 32'hFFFF_FFFE;
               2, 3, 4: stamp = $urandom_range(15);
               default: stamp = $urandom;
            endcase
            send_request(commit_item(random_intent(), random_intent(), stamp));
            sent++;
         end
         burst = $urandom_range(0, 60);
         repeat (burst) begin
            send_request(tick_item(chance(75) ? 16'($urandom_range(16384, 65535))
                                              : 16'($urandom)));
            sent++;
         end
         if (chance(6)) begin
            send_request(kind_item(KIND_RESET));
            sent++;
         end
         if (chance(4)) begin
            send_request(kind_item(KIND_UNUSED));
         end
         if (chance(8)) begin
            item = kind_item(2'($urandom_range(3)));
            send_request(item);
            if (item.req_type != KIND_UNUSED) begin
               sent++;
            end
         end
      end
   endtask

   initial begin
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_data     = '0;
      rsp_ready    = 1'b0;
      req_idle_pct = 6;
      rsp_idle_pct = 53;
      lock_owner        = OWN_NONE;
      pend_stamp[OWN_A] = STAMP_NONE;
      pend_stamp[OWN_B] = STAMP_NONE;
      rest_left         = '0;
      rest_rng          = RNG_SEED;

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_unused_kind();
      test_grant_order();
      test_rest_ticks();
      test_reset_item();
      test_random_traffic(6, 53, 670);
      test_random_traffic(53, 6, 670);
      test_random_traffic(0, 0, 670);
      req_valid = 1'b0;

      while (expected_states.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d commits, %0d ticks and %0d reset requests; checked %0d results.",
               commit_count, tick_count, reset_item_count, results_checked);
      $display("Lock granted to A %0d times and to B %0d times; %0d rest periods started.",
               grants_a, grants_b, rest_starts);
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

@@ sim.f @@
hw/rtl/tcfl_pkg.sv
hw/rtl/tcfl_in_reg.sv
hw/rtl/tcfl_lock_core.sv
hw/rtl/tcfl_out_reg.sv
hw/rtl/two_client_fcfs_lock_with_random_rest.sv
dv/tb.sv
